[rtl/core/bbc_pkg.sv]
package bbc_pkg;

  // Field widths of the token and result channels and of the stack entry kind
  localparam int CHAR_W   = 8;
  localparam int TOKEN_W  = 16;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 2;

  // Default sizing
  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_INDEX_BITS  = 16;

  // Item kinds on the token channel
  localparam logic MODE_TOKEN = 1'b0;
  localparam logic MODE_END   = 1'b1;

  // Bracket characters
  localparam logic [CHAR_W-1:0] CH_PAREN_OPEN    = 8'h28;
  localparam logic [CHAR_W-1:0] CH_PAREN_CLOSE   = 8'h29;
  localparam logic [CHAR_W-1:0] CH_BRACE_OPEN    = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_BRACE_CLOSE   = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_BRACKET_OPEN  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_BRACKET_CLOSE = 8'h5D;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_PAREN   = 2'd0;
  localparam kind_t KIND_BRACE   = 2'd1;
  localparam kind_t KIND_BRACKET = 2'd2;
  localparam kind_t KIND_NONE    = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_CLOSE    = 2'd1,
    ST_OPEN     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // Shift controls for one stack cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  // One result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TOKEN_W-1:0]  error_token;
    logic                list_done;
  } result_t;

  function automatic kind_t open_kind(input logic [CHAR_W-1:0] c);
    kind_t k;
    case (c)
      CH_PAREN_OPEN:   k = KIND_PAREN;
      CH_BRACE_OPEN:   k = KIND_BRACE;
      CH_BRACKET_OPEN: k = KIND_BRACKET;
      default:         k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t close_kind(input logic [CHAR_W-1:0] c);
    kind_t k;
    case (c)
      CH_PAREN_CLOSE:   k = KIND_PAREN;
      CH_BRACE_CLOSE:   k = KIND_BRACE;
      CH_BRACKET_CLOSE: k = KIND_BRACKET;
      default:          k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

[rtl/core/bbc_if.sv]
interface bbc_token_if import bbc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [CHAR_W-1:0]  bracket_char;
  logic [TOKEN_W-1:0] token_index;

  modport source (output valid, mode, bracket_char, token_index, input ready);
  modport sink   (input valid, mode, bracket_char, token_index, output ready);
endinterface

interface bbc_result_if import bbc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TOKEN_W-1:0]  error_token;
  logic                list_done;

  modport source (output valid, status, error_token, list_done, input ready);
  modport sink   (input valid, status, error_token, list_done, output ready);
endinterface

[rtl/core/bracket_balance_checker.sv]
// Bracket balance checker.
//
// Channels: "tokens" takes one transaction per token (mode = token) or per
// end of list (mode = end); "results" returns exactly one transaction for
// each token transaction, in order. A token result carries the sticky error
// status as it stands after that token; an end result carries the verdict of
// the whole list (list_done = 1) and empties the stack for the next list.
//
// Each result is registered in the output stage before it appears on
// "results". Throughput: one token per cycle, sustained while the skid
// register is empty. The stack top sits in the first cell of a shifting
// chain, so each token is decided from registered state.
//
// Reset (rst, synchronous): empties the stack, clears the sticky error and
// drops any pending result. No clearing pass is needed.
//
// Receiver stall: a two-entry output stage (output register plus skid
// register) absorbs one extra result; tokens.ready drops only while both
// are full, and rises again the cycle after the receiver takes one.
module bracket_balance_checker import bbc_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
  input  logic          clk,
  input  logic          rst,
  bbc_token_if.sink     tokens,
  bbc_result_if.source  results
);

  // Only the low index bits that also fit the token field are kept
  localparam int KEEP_BITS = (INDEX_BITS < TOKEN_W) ? INDEX_BITS : TOKEN_W;
  localparam int ENTRY_W   = KIND_W + KEEP_BITS;
  localparam int COUNT_W   = $clog2(STACK_DEPTH + 1);

  logic [ENTRY_W-1:0] stack_q [STACK_DEPTH];
  logic [COUNT_W-1:0] stack_count;
  status_t            error_status;
  logic [KEEP_BITS-1:0] error_index;

  logic               in_ready;
  logic               in_fire;
  cell_ctrl_t         ctrl;
  logic [ENTRY_W-1:0] push_entry;
  logic [COUNT_W-1:0] stack_count_next;
  status_t            error_status_next;
  logic [KEEP_BITS-1:0] error_index_next;
  result_t            result;

  kind_t                top_kind;
  logic [KEEP_BITS-1:0] top_index;
  kind_t                ck;
  kind_t                ok;
  logic [KEEP_BITS-1:0] idx;
  logic                 stack_empty;
  logic                 stack_full;

  assign tokens.ready = in_ready;
  assign in_fire      = tokens.valid && in_ready;

  assign idx         = tokens.token_index[KEEP_BITS-1:0];
  assign ck          = close_kind(tokens.bracket_char);
  assign ok          = open_kind(tokens.bracket_char);
  assign top_kind    = stack_q[0][ENTRY_W-1 -: KIND_W];
  assign top_index   = stack_q[0][KEEP_BITS-1:0];
  assign stack_empty = (stack_count == '0);
  assign stack_full  = (stack_count == COUNT_W'(STACK_DEPTH));
  assign push_entry  = {ok, idx};

  // Decide the transaction against the stack top and the sticky error
  always_comb begin
    ctrl              = '0;
    stack_count_next  = stack_count;
    error_status_next = error_status;
    error_index_next  = error_index;
    result            = '0;

    if (tokens.mode == MODE_TOKEN) begin
      if (error_status == ST_OK) begin
        if (ck != KIND_NONE) begin
          if (stack_empty || top_kind != ck) begin
            error_status_next = ST_CLOSE;
            error_index_next  = idx;
          end else begin
            ctrl.pop         = 1'b1;
            stack_count_next = stack_count - COUNT_W'(1);
          end
        end else if (ok != KIND_NONE) begin
          if (stack_full) begin
            error_status_next = ST_OVERFLOW;
            error_index_next  = idx;
          end else begin
            ctrl.push        = 1'b1;
            stack_count_next = stack_count + COUNT_W'(1);
          end
        end
      end
      result.status      = error_status_next;
      result.error_token = (error_status_next == ST_OK) ? '0 : TOKEN_W'(error_index_next);
      result.list_done   = 1'b0;
    end else begin
      // End of list: report the verdict, then start clean
      if (error_status != ST_OK) begin
        result.status      = error_status;
        result.error_token = TOKEN_W'(error_index);
      end else if (!stack_empty) begin
        result.status      = ST_OPEN;
        result.error_token = TOKEN_W'(top_index);
      end else begin
        result.status      = ST_OK;
        result.error_token = '0;
      end
      result.list_done  = 1'b1;
      stack_count_next  = '0;
      error_status_next = ST_OK;
      error_index_next  = '0;
    end

    // Hold everything unless a transaction is taken
    if (!in_fire) begin
      ctrl              = '0;
      stack_count_next  = stack_count;
      error_status_next = error_status;
      error_index_next  = error_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count  <= '0;
      error_status <= ST_OK;
      error_index  <= '0;
    end else begin
      stack_count  <= stack_count_next;
      error_status <= error_status_next;
      error_index  <= error_index_next;
    end
  end

  // Stack storage: a chain of cells, cell 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [ENTRY_W-1:0] above;
    logic [ENTRY_W-1:0] below;

    if (i == 0) begin : g_top
      assign above = push_entry;
    end else begin : g_mid
      assign above = stack_q[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = stack_q[i];
    end else begin : g_inner
      assign below = stack_q[i+1];
    end

    bbc_cell #(
      .ENTRY_W(ENTRY_W)
    ) u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .above(above),
      .below(below),
      .entry(stack_q[i])
    );
  end

  // Decouple the result channel from the token channel
  bbc_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_fire),
    .in_ready(in_ready),
    .in_data (result),
    .res     (results)
  );

endmodule

[rtl/core/bbc_cell.sv]
module bbc_cell import bbc_pkg::*; #(
  parameter int ENTRY_W = KIND_W + DEF_INDEX_BITS
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [ENTRY_W-1:0] above,
  input  logic [ENTRY_W-1:0] below,
  output logic [ENTRY_W-1:0] entry
);

  // Push shifts the stack away from the top, pop shifts it toward the top
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry <= above;
    end else if (ctrl.pop) begin
      entry <= below;
    end
  end

endmodule

[rtl/core/bbc_out_stage.sv]
module bbc_out_stage import bbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  result_t              in_data,
  bbc_result_if.source         res
);

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    out_fire;
  logic    in_fire;

  assign in_ready = !skid_valid;
  assign out_fire = out_valid && res.ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid && out_fire) begin
        // drain the skid entry into the output register
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (in_fire) begin
        if (!out_valid || out_fire) begin
          out_valid <= 1'b1;
          out_data  <= in_data;
        end else begin
          skid_valid <= 1'b1;
          skid_data  <= in_data;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_data.status;
  assign res.error_token = out_data.error_token;
  assign res.list_done   = out_data.list_done;

endmodule

[rtl/core/bbc_checker.sv]
module bbc_checker import bbc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                tok_ready,
  input logic                res_valid,
  input logic                res_ready,
  input logic [STATUS_W-1:0] res_status,
  input logic [TOKEN_W-1:0]  res_error_token
);

  // A stalled result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // A clean status never names a token
  a_ok_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_OK |-> res_error_token == '0)
    else $error("ok result with nonzero error_token");

  // Back pressure only when results are waiting
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !tok_ready |-> res_valid)
    else $error("tokens refused with no pending result");

  // Reset drops pending results
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
  .clk            (clk),
  .rst            (rst),
  .tok_ready      (tokens.ready),
  .res_valid      (results.valid),
  .res_ready      (results.ready),
  .res_status     (results.status),
  .res_error_token(results.error_token)
);
